@@ hdl/tli_pkg.sv @@
// shared types and constants for the table linear interpolator
// used by tli_muldiv and table_linear_interpolator_top; no dependencies
package tli_pkg;

    // field widths
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;

    // default table depth
    localparam int DEF_TABLE_DEPTH = 4096;

    // item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // request to the shared multiply/divide unit
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] dt;
        logic [DATA_W-1:0] span;
    } t_md_req;

    // response from the shared multiply/divide unit
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } t_md_rsp;

endpackage

@@ hdl/tli_muldiv.sv @@
// shift-add multiplier and restoring divider on one set of registers
// computes round(mag * dt / span); depends on tli_pkg
module tli_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tli_pkg::t_md_req i_req,
    output tli_pkg::t_md_rsp o_rsp
);
    import tli_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

    localparam int CNT_W = $clog2(DATA_W);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_mag, n_mag;
    logic [DATA_W-1:0] r_span, n_span;
    logic [DATA_W-1:0] r_hi, n_hi;
    logic [DATA_W-1:0] r_lo, n_lo;

    logic [DATA_W:0]     mul_sum;
    logic [2*DATA_W:0]   dividend;
    logic [DATA_W:0]     rem_shift;
    logic [DATA_W:0]     rem_diff;
    logic                rem_ge;

    // one multiply step: add mag when the low multiplier bit is set
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mag} : '0);

    // rounding offset of half the span added to the product
    assign dividend = {1'b0, r_hi, r_lo} + (2*DATA_W+1)'(r_span >> 1);

    // one divide step: shift in the next dividend bit and try to subtract
    assign rem_shift = {r_hi, r_lo[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_span};
    assign rem_ge    = (rem_shift >= {1'b0, r_span});

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_span  = r_span;
        n_hi    = r_hi;
        n_lo    = r_lo;
        case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_mag   = i_req.mag;
                    n_span  = i_req.span;
                    n_hi    = '0;
                    n_lo    = i_req.dt;
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_hi  = mul_sum[DATA_W:1];
                n_lo  = {mul_sum[0], r_lo[DATA_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                // high half is below span, so it seeds the remainder
                n_hi    = dividend[2*DATA_W-1:DATA_W];
                n_lo    = dividend[DATA_W-1:0];
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_hi  = rem_ge ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
                n_lo  = {r_lo[DATA_W-2:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_mag  <= n_mag;
        r_span <= n_span;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
    end

    assign o_rsp.done = (r_state == ST_DONE);
    assign o_rsp.quot = r_lo;

endmodule

@@ hdl/table_linear_interpolator_top.sv @@
// Table linear interpolator: (time, value) table with binary search lookup.
// Input channel (i_in_valid / o_in_stall) takes load and query items. A load
// writes one table entry and gives no result. A query gives
// one result item on the output channel (o_out_valid / i_out_stall).
// The configuration channel (i_cfg_valid / o_cfg_ready) writes sample_count,
// the number of entries in use; it is always ready. The user must write it only
// while idle; the block itself does not enforce this. A query is compared first
// with entry zero and then with the last active entry; at or outside either
// end it gives that entry's value, marked clamped. Otherwise a binary search
// (up to log2 of the table depth probes) on the single read port of the table
// memory finds an exact hit or the pair around the query, and the value is
// interpolated by the shared shift-add multiplier and restoring divider, one
// bit per cycle. One item is in progress at a time: o_in_stall is high from
// the accept of a query until its result has been taken.
// When the receiver stalls, the result is held on the output until taken.
// Reset sets sample_count to 1 and returns the sequencer to idle; the table
// contents are not cleared and must be loaded before they are queried.
module table_linear_interpolator_top #(
    parameter int TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [tli_pkg::INDEX_W-1:0] i_entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0] i_sample_time,
    input  logic signed [tli_pkg::DATA_W-1:0] i_sample_value,
    // result items
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [tli_pkg::DATA_W-1:0] o_interpolated_value,
    output logic                        o_clamped,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tli_pkg::COUNT_W-1:0] i_cfg_sample_count
);
    import tli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam int XW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOW,
        ST_HIGH,
        ST_PROBE,
        ST_ZERO,
        ST_RD1,
        ST_RD0,
        ST_PREP,
        ST_CALC,
        ST_OUT
    } t_state;

    // table memories
    logic [DATA_W-1:0] time_mem  [TABLE_DEPTH];
    logic [DATA_W-1:0] value_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] r_t_rd;
    logic [DATA_W-1:0] r_v_rd;

    t_state            r_state, n_state;
    logic [COUNT_W-1:0] r_count;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_lo, n_lo;
    logic [AW-1:0]     r_hi, n_hi;
    logic [AW-1:0]     r_last, n_last;
    logic [DATA_W-1:0] r_q, n_q;
    logic [DATA_W-1:0] r_t1, n_t1;
    logic [DATA_W-1:0] r_v1, n_v1;
    logic [DATA_W-1:0] r_v0, n_v0;
    logic [DATA_W:0]   r_span, n_span;
    logic [DATA_W:0]   r_dt, n_dt;
    logic [DATA_W:0]   r_dv, n_dv;
    t_md_req           r_md_req, n_md_req;
    t_md_rsp           md_rsp;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic              r_out_clamped, n_out_clamped;

    logic              in_acc;
    logic              load_ok;
    logic [XW-1:0]     idx_ext;
    logic [AW-1:0]     wr_addr;
    logic [CW-1:0]     cnt_ext;
    logic [CW-1:0]     n_eff;
    logic              q_le_rd;
    logic              q_ge_rd;
    logic              q_eq_rd;
    logic              rd_lt_q;
    logic [AW-1:0]     pr_lo;
    logic [AW-1:0]     pr_hi;
    logic [AW:0]       mid_sum;
    logic [AW:0]       pr_mid_sum;
    logic [DATA_W-1:0] dt_clip;
    logic [DATA_W:0]   dv_abs;
    logic [DATA_W+2:0] final_sum;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // load address check against the table depth
    assign idx_ext = XW'(i_entry_index);
    assign load_ok = (idx_ext < XW'(TABLE_DEPTH));
    assign wr_addr = idx_ext[AW-1:0];

    // effective entry count: zero acts as one, above depth acts as depth
    assign cnt_ext = CW'(r_count);
    always_comb begin
        if (cnt_ext == '0) begin
            n_eff = CW'(1);
        end else if (cnt_ext > CW'(TABLE_DEPTH)) begin
            n_eff = CW'(TABLE_DEPTH);
        end else begin
            n_eff = cnt_ext;
        end
    end

    // comparisons of the query against the entry just read
    assign q_le_rd = ($signed(r_q) <= $signed(r_t_rd));
    assign q_ge_rd = ($signed(r_q) >= $signed(r_t_rd));
    assign q_eq_rd = (r_q == r_t_rd);
    assign rd_lt_q = ($signed(r_t_rd) < $signed(r_q));

    // search bounds after the current probe
    assign pr_lo      = rd_lt_q ? (r_addr + 1'b1) : r_lo;
    assign pr_hi      = rd_lt_q ? r_hi : r_addr;
    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_last};
    assign pr_mid_sum = {1'b0, pr_lo} + {1'b0, pr_hi};

    // clipped time offset and value step magnitude
    always_comb begin
        if (r_dt[DATA_W]) begin
            dt_clip = '0;
        end else if (r_dt > r_span) begin
            dt_clip = r_span[DATA_W-1:0];
        end else begin
            dt_clip = r_dt[DATA_W-1:0];
        end
    end
    assign dv_abs = r_dv[DATA_W] ? (~r_dv + 1'b1) : r_dv;

    // base value plus or minus the rounded correction
    assign final_sum = r_dv[DATA_W]
        ? ({{3{r_v0[DATA_W-1]}}, r_v0} - {3'b000, md_rsp.quot})
        : ({{3{r_v0[DATA_W-1]}}, r_v0} + {3'b000, md_rsp.quot});

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_last        = r_last;
        n_q           = r_q;
        n_t1          = r_t1;
        n_v1          = r_v1;
        n_v0          = r_v0;
        n_span        = r_span;
        n_dt          = r_dt;
        n_dv          = r_dv;
        n_md_req      = r_md_req;
        n_md_req.start = 1'b0;
        n_out_value   = r_out_value;
        n_out_clamped = r_out_clamped;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_opcode == OP_QUERY) begin
                    n_q     = i_sample_time;
                    n_last  = AW'(n_eff - CW'(1));
                    n_lo    = '0;
                    n_addr  = '0;
                    n_state = ST_LOW;
                end
            end
            ST_LOW: begin
                // entry zero is on the read port
                if (q_le_rd) begin
                    n_out_value   = r_v_rd;
                    n_out_clamped = 1'b1;
                    n_state       = ST_OUT;
                end else begin
                    n_addr  = r_last;
                    n_state = ST_HIGH;
                end
            end
            ST_HIGH: begin
                // last active entry is on the read port
                if (q_ge_rd) begin
                    n_out_value   = r_v_rd;
                    n_out_clamped = 1'b1;
                    n_state       = ST_OUT;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_last;
                    n_addr  = mid_sum[AW:1];
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (q_eq_rd) begin
                    n_out_value   = r_v_rd;
                    n_out_clamped = 1'b0;
                    n_state       = ST_OUT;
                end else begin
                    n_lo = pr_lo;
                    n_hi = pr_hi;
                    if (pr_lo < pr_hi) begin
                        n_addr = pr_mid_sum[AW:1];
                    end else if (pr_lo == '0) begin
                        // search ended at entry zero
                        n_addr  = '0;
                        n_state = ST_ZERO;
                    end else begin
                        n_addr  = pr_lo;
                        n_state = ST_RD1;
                    end
                end
            end
            ST_ZERO: begin
                n_out_value   = r_v_rd;
                n_out_clamped = 1'b0;
                n_state       = ST_OUT;
            end
            ST_RD1: begin
                n_t1    = r_t_rd;
                n_v1    = r_v_rd;
                n_addr  = r_lo - 1'b1;
                n_state = ST_RD0;
            end
            ST_RD0: begin
                n_v0    = r_v_rd;
                n_span  = {r_t1[DATA_W-1], r_t1} - {r_t_rd[DATA_W-1], r_t_rd};
                n_dt    = {r_q[DATA_W-1], r_q} - {r_t_rd[DATA_W-1], r_t_rd};
                n_dv    = {r_v1[DATA_W-1], r_v1} - {r_v_rd[DATA_W-1], r_v_rd};
                n_state = ST_PREP;
            end
            ST_PREP: begin
                if (r_span[DATA_W] || r_span == '0) begin
                    // times do not ascend across this pair
                    n_out_value   = r_v1;
                    n_out_clamped = 1'b0;
                    n_state       = ST_OUT;
                end else begin
                    n_md_req.start = 1'b1;
                    n_md_req.mag   = dv_abs[DATA_W-1:0];
                    n_md_req.dt    = dt_clip;
                    n_md_req.span  = r_span[DATA_W-1:0];
                    n_state        = ST_CALC;
                end
            end
            ST_CALC: begin
                if (md_rsp.done) begin
                    if (final_sum[DATA_W+2:DATA_W-1] == '0
                        || final_sum[DATA_W+2:DATA_W-1] == '1) begin
                        n_out_value = final_sum[DATA_W-1:0];
                    end else if (final_sum[DATA_W+2]) begin
                        n_out_value = SAT_MIN;
                    end else begin
                        n_out_value = SAT_MAX;
                    end
                    n_out_clamped = 1'b0;
                    n_state       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= COUNT_W'(1);
            r_md_req.start <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_md_req.start <= n_md_req.start;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_sample_count;
            end
        end
        r_md_req.mag  <= n_md_req.mag;
        r_md_req.dt   <= n_md_req.dt;
        r_md_req.span <= n_md_req.span;
        r_addr        <= n_addr;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_last        <= n_last;
        r_q           <= n_q;
        r_t1          <= n_t1;
        r_v1          <= n_v1;
        r_v0          <= n_v0;
        r_span        <= n_span;
        r_dt          <= n_dt;
        r_dv          <= n_dv;
        r_out_value   <= n_out_value;
        r_out_clamped <= n_out_clamped;
    end

    // table memory: write on load items, registered read at the next address
    always_ff @(posedge i_clk) begin
        if (in_acc && i_opcode == OP_LOAD && load_ok) begin
            time_mem[wr_addr]  <= i_sample_time;
            value_mem[wr_addr] <= i_sample_value;
        end
        r_t_rd <= time_mem[n_addr];
        r_v_rd <= value_mem[n_addr];
    end

    // shared multiply and divide unit
    tli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_md_req),
        .o_rsp   (md_rsp)
    );

    assign o_in_stall           = (r_state != ST_IDLE);
    assign o_out_valid          = (r_state == ST_OUT);
    assign o_interpolated_value = r_out_value;
    assign o_clamped            = r_out_clamped;

endmodule
